// File: hw/rtl/ked_pkg.sv
// ----------------------------------------------------------------------------
// ked_pkg
// Shared constants, types and helpers of the key event detector.
// ----------------------------------------------------------------------------
package ked_pkg;

  localparam int KEY_W    = 4;
  localparam int NUM_KEYS = 16;
  localparam int KEY_DEPTH = 1 << KEY_W;
  localparam int TIME_W   = 16;
  localparam int TICK_W   = 15;
  localparam int MASK_W   = 5;
  localparam int CNT_W    = 8;
  localparam int DOWN_W   = 5;
  localparam int FLAG_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam int DOWN_MAX_I = (NUM_KEYS < 31) ? NUM_KEYS : 31;
  localparam logic [DOWN_W-1:0] DOWN_MAX = DOWN_W'(DOWN_MAX_I);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_INT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_INIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REP_PER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FEAT_MASK = 3'd5;

  // register reset values
  localparam logic [TICK_W-1:0] RST_DEBOUNCE  = 15'd20;
  localparam logic [TICK_W-1:0] RST_LONG_HOLD = 15'd1000;
  localparam logic [TICK_W-1:0] RST_MULTI_INT = 15'd300;
  localparam logic [TICK_W-1:0] RST_REP_INIT  = 15'd1000;
  localparam logic [TICK_W-1:0] RST_REP_PER   = 15'd100;
  localparam logic [MASK_W-1:0] RST_FEAT_MASK = 5'd31;

  // feature mask bits
  localparam int FM_LONG_P  = 0;
  localparam int FM_LONG_R  = 1;
  localparam int FM_MULTI_P = 2;
  localparam int FM_MULTI_R = 3;
  localparam int FM_REPEAT  = 4;

  // per-key status flags
  localparam logic [FLAG_W-1:0] F_PRESS    = 10'h001;
  localparam logic [FLAG_W-1:0] F_RELEASE  = 10'h002;
  localparam logic [FLAG_W-1:0] F_PRESSING = 10'h004;
  localparam logic [FLAG_W-1:0] F_PRESS_DB = 10'h008;
  localparam logic [FLAG_W-1:0] F_HOLD_DB  = 10'h010;
  localparam logic [FLAG_W-1:0] F_LONG_P   = 10'h020;
  localparam logic [FLAG_W-1:0] F_LONG_R   = 10'h040;
  localparam logic [FLAG_W-1:0] F_MULTI_P  = 10'h080;
  localparam logic [FLAG_W-1:0] F_MULTI_R  = 10'h100;
  localparam logic [FLAG_W-1:0] F_REPEAT   = 10'h200;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic              stable;
    logic [FLAG_W-1:0] flags;
    time_t             db_dl;
    time_t             lp_dl;
    time_t             lr_dl;
    logic              fired;
    logic [CNT_W-1:0]  pcc;
    time_t             pcd;
    logic [CNT_W-1:0]  rcc;
    time_t             rcd;
    time_t             rep_dl;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic              pressed;
    logic              released;
    logic              held;
    logic              debouncing;
    logic              long_hold;
    logic              long_rel;
    logic [CNT_W-1:0]  multi_press_count;
    logic [CNT_W-1:0]  multi_release_count;
    logic              repeat_res;
    logic [DOWN_W-1:0] keys_down;
  } key_result_t;

  // deadline reached: (now - dl) mod 2^TIME_W below half range
  function automatic logic reached(input time_t now, input time_t dl);
    time_t diff;
    diff = now - dl;
    return ~diff[TIME_W-1];
  endfunction

  function automatic time_t after_t(input time_t now, input logic [TICK_W-1:0] ticks);
    return now + TIME_W'(ticks);
  endfunction

endpackage

// File: hw/rtl/ked_in_if.sv
// ----------------------------------------------------------------------------
// ked_in_if
// Sample channel: one key level word per handshake.
// ----------------------------------------------------------------------------
interface ked_in_if;
  logic                    valid;
  logic                    ready;
  logic [ked_pkg::KEY_W-1:0] key_index;
  logic                    level;
  logic                    tick;

  modport source (output valid, key_index, level, tick, input ready);
  modport sink   (input valid, key_index, level, tick, output ready);
endinterface

// File: hw/rtl/ked_out_if.sv
// ----------------------------------------------------------------------------
// ked_out_if
// Result channel: one event word per handshake.
// ----------------------------------------------------------------------------
interface ked_out_if;
  logic                       valid;
  logic                       ready;
  logic [ked_pkg::KEY_W-1:0]  key_id;
  logic                       pressed;
  logic                       released;
  logic                       held;
  logic                       debouncing;
  logic                       long_hold;
  logic                       long_rel;
  logic [ked_pkg::CNT_W-1:0]  multi_press_count;
  logic [ked_pkg::CNT_W-1:0]  multi_release_count;
  logic                       repeat_res;
  logic [ked_pkg::DOWN_W-1:0] keys_down;

  modport source (output valid, key_id, pressed, released, held, debouncing, long_hold,
                  long_rel, multi_press_count, multi_release_count, repeat_res,
                  keys_down, input ready);
  modport sink   (input valid, key_id, pressed, released, held, debouncing, long_hold,
                  long_rel, multi_press_count, multi_release_count, repeat_res,
                  keys_down, output ready);
endinterface

// File: hw/rtl/ked_ram.sv
// ----------------------------------------------------------------------------
// ked_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ked_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/key_event_detector_top.sv
// ----------------------------------------------------------------------------
// key_event_detector_top
// Per-key debounce, long press, multi-click and auto-repeat detection.
// ----------------------------------------------------------------------------
// One result word per sample word. The block takes one sample per clock when
// the result side keeps up; the key's state entry is read from the state RAM
// in the accept cycle, then modified and written back when the update stage
// advances, while the result goes to the output register. Back-to-back
// samples of the same key are served from a forwarding register of the last
// write. RAM entries never written read as the reset state through per-key
// valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module key_event_detector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  ked_in_if.sink                         in_ch,
  ked_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ked_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ked_pkg::TICK_W-1:0]     cfg_wdata
);

  // config registers
  logic [ked_pkg::TICK_W-1:0] dbt_r, lht_r, mit_r, rit_r, rpt_r;
  logic [ked_pkg::MASK_W-1:0] fm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbt_r <= ked_pkg::RST_DEBOUNCE;
      lht_r <= ked_pkg::RST_LONG_HOLD;
      mit_r <= ked_pkg::RST_MULTI_INT;
      rit_r <= ked_pkg::RST_REP_INIT;
      rpt_r <= ked_pkg::RST_REP_PER;
      fm_r  <= ked_pkg::RST_FEAT_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ked_pkg::REG_DEBOUNCE:  dbt_r <= cfg_wdata;
        ked_pkg::REG_LONG_HOLD: lht_r <= cfg_wdata;
        ked_pkg::REG_MULTI_INT: mit_r <= cfg_wdata;
        ked_pkg::REG_REP_INIT:  rit_r <= cfg_wdata;
        ked_pkg::REG_REP_PER:   rpt_r <= cfg_wdata;
        ked_pkg::REG_FEAT_MASK: fm_r  <= cfg_wdata[ked_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                       s1_vld_r;
  logic [ked_pkg::KEY_W-1:0]  s1_key_r;
  logic                       s1_lvl_r;
  ked_pkg::time_t             s1_time_r;
  ked_pkg::time_t             time_r;
  ked_pkg::time_t             time_nxt;
  logic                       out_vld_r;
  ked_pkg::key_result_t       res_r;
  ked_pkg::key_result_t       res_nxt;
  logic [ked_pkg::DOWN_W-1:0] down_r;
  logic [ked_pkg::DOWN_W-1:0] down_nxt;
  logic                       acc;
  logic                       adv;
  logic                       in_range;
  logic                       wr_en;

  assign adv          = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || adv;
  assign acc          = in_ch.valid && in_ch.ready;
  assign time_nxt     = in_ch.tick ? time_r + ked_pkg::time_t'(1) : time_r;
  assign in_range     = {1'b0, s1_key_r} < (ked_pkg::KEY_W + 1)'(ked_pkg::NUM_KEYS);
  assign wr_en        = adv && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      time_r   <= '0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
        time_r   <= time_nxt;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_key_r  <= in_ch.key_index;
      s1_lvl_r  <= in_ch.level;
      s1_time_r <= time_nxt;
    end
  end

  // state memory, valid bits and forwarding
  logic [ked_pkg::ENTRY_W-1:0]   ram_rdata;
  ked_pkg::key_entry_t           cur;
  ked_pkg::key_entry_t           nxt;
  logic [ked_pkg::KEY_DEPTH-1:0] ent_vld_r;
  logic                          fwd_vld_r;
  logic [ked_pkg::KEY_W-1:0]     fwd_key_r;
  ked_pkg::key_entry_t           fwd_data_r;

  ked_ram #(
    .WIDTH (ked_pkg::ENTRY_W),
    .DEPTH (ked_pkg::KEY_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_key_r),
    .wdata (nxt),
    .re    (acc),
    .raddr (in_ch.key_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      ent_vld_r[s1_key_r] <= 1'b1;
      fwd_vld_r           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_key_r  <= s1_key_r;
      fwd_data_r <= nxt;
    end
  end

  always_comb begin
    if (fwd_vld_r && (fwd_key_r == s1_key_r)) begin
      cur = fwd_data_r;
    end else if (ent_vld_r[s1_key_r]) begin
      cur = ked_pkg::key_entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // per-key update
  logic [ked_pkg::FLAG_W-1:0] f;
  logic [ked_pkg::FLAG_W-1:0] fo;
  logic [ked_pkg::CNT_W-1:0]  pc1;
  logic [ked_pkg::CNT_W-1:0]  rc1;
  logic                       held_ev, press_ev, rel_ev, lp_ev, lr_ev, rep_ev, deb;
  logic [ked_pkg::CNT_W-1:0]  mp, mr;
  logic                       hold_like;

  always_comb begin
    nxt      = cur;
    f        = cur.flags;
    held_ev  = 1'b0;
    press_ev = 1'b0;
    rel_ev   = 1'b0;
    lp_ev    = 1'b0;
    lr_ev    = 1'b0;
    rep_ev   = 1'b0;
    mp       = '0;
    mr       = '0;
    pc1      = cur.pcc;
    rc1      = cur.rcc;

    // debounce
    unique case ({s1_lvl_r, cur.stable})
      2'b00: begin
        nxt.db_dl = '0;
        f         = '0;
      end
      2'b11: begin
        nxt.db_dl = '0;
        f         = ked_pkg::F_PRESSING;
        held_ev   = 1'b1;
      end
      default: begin
        priority if ((dbt_r == '0) ||
                     ((cur.db_dl != '0) && ked_pkg::reached(s1_time_r, cur.db_dl))) begin
          f        = s1_lvl_r ? ked_pkg::F_PRESS : ked_pkg::F_RELEASE;
          press_ev = s1_lvl_r;
          rel_ev   = !s1_lvl_r;
        end else if (cur.db_dl == '0) begin
          f         = s1_lvl_r ? ked_pkg::F_PRESS_DB : ked_pkg::F_HOLD_DB;
          nxt.db_dl = ked_pkg::after_t(s1_time_r, dbt_r);
        end else begin
          f = cur.flags;
        end
      end
    endcase

    deb = |(f & (ked_pkg::F_PRESS_DB | ked_pkg::F_HOLD_DB));
    if (!deb) begin
      nxt.stable = s1_lvl_r;
    end
    hold_like = |(f & (ked_pkg::F_PRESSING | ked_pkg::F_HOLD_DB));
    fo = f;

    // long press / long release
    priority if (|(f & ked_pkg::F_PRESS)) begin
      nxt.lp_dl = ked_pkg::after_t(s1_time_r, lht_r);
      nxt.lr_dl = ked_pkg::after_t(s1_time_r, lht_r);
      nxt.fired = 1'b0;
    end else if (hold_like) begin
      if (fm_r[ked_pkg::FM_LONG_P] && ked_pkg::reached(s1_time_r, cur.lp_dl) && !cur.fired) begin
        nxt.fired = 1'b1;
        fo        = fo | ked_pkg::F_LONG_P;
        lp_ev     = 1'b1;
      end
    end else if (|(f & ked_pkg::F_RELEASE)) begin
      if (fm_r[ked_pkg::FM_LONG_R] && ked_pkg::reached(s1_time_r, cur.lr_dl)) begin
        fo    = fo | ked_pkg::F_LONG_R;
        lr_ev = 1'b1;
      end
    end else begin
      nxt.fired = cur.fired;
    end

    // multi-click, presses
    if (fm_r[ked_pkg::FM_MULTI_P] && |(f & ked_pkg::F_PRESS)) begin
      if (cur.pcc != ked_pkg::CNT_MAX) begin
        pc1 = cur.pcc + ked_pkg::CNT_W'(1);
      end
      if (pc1 >= ked_pkg::CNT_W'(2)) begin
        fo = fo | ked_pkg::F_MULTI_P;
        mp = pc1;
      end
      nxt.pcd = ked_pkg::after_t(s1_time_r, mit_r);
    end
    nxt.pcc = ((pc1 != '0) && ked_pkg::reached(s1_time_r, nxt.pcd)) ? '0 : pc1;

    // multi-click, releases
    if (fm_r[ked_pkg::FM_MULTI_R] && |(f & ked_pkg::F_RELEASE)) begin
      if (cur.rcc != ked_pkg::CNT_MAX) begin
        rc1 = cur.rcc + ked_pkg::CNT_W'(1);
      end
      if (rc1 >= ked_pkg::CNT_W'(2)) begin
        fo = fo | ked_pkg::F_MULTI_R;
        mr = rc1;
      end
      nxt.rcd = ked_pkg::after_t(s1_time_r, mit_r);
    end
    nxt.rcc = ((rc1 != '0) && ked_pkg::reached(s1_time_r, nxt.rcd)) ? '0 : rc1;

    // auto-repeat
    priority if (|(f & ked_pkg::F_PRESS)) begin
      nxt.rep_dl = ked_pkg::after_t(s1_time_r, rit_r);
    end else if (hold_like) begin
      if (fm_r[ked_pkg::FM_REPEAT] && ked_pkg::reached(s1_time_r, cur.rep_dl)) begin
        fo         = fo | ked_pkg::F_REPEAT;
        rep_ev     = 1'b1;
        nxt.rep_dl = ked_pkg::after_t(s1_time_r, rpt_r);
      end
    end else begin
      nxt.rep_dl = cur.rep_dl;
    end

    nxt.flags = fo;
  end

  // down count
  always_comb begin
    down_nxt = down_r;
    if (in_range) begin
      priority if (|(f & ked_pkg::F_PRESS)) begin
        if (down_r < ked_pkg::DOWN_MAX) begin
          down_nxt = down_r + ked_pkg::DOWN_W'(1);
        end
      end else if (|(f & ked_pkg::F_RELEASE)) begin
        if (down_r != '0) begin
          down_nxt = down_r - ked_pkg::DOWN_W'(1);
        end
      end else begin
        down_nxt = down_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r <= '0;
    end else if (adv) begin
      down_r <= down_nxt;
    end
  end

  // result word
  always_comb begin
    res_nxt                     = '0;
    res_nxt.key_id              = s1_key_r;
    res_nxt.keys_down           = down_nxt;
    if (in_range) begin
      res_nxt.pressed             = press_ev;
      res_nxt.released            = rel_ev;
      res_nxt.held                = held_ev;
      res_nxt.debouncing          = deb;
      res_nxt.long_hold           = lp_ev;
      res_nxt.long_rel            = lr_ev;
      res_nxt.multi_press_count   = mp;
      res_nxt.multi_release_count = mr;
      res_nxt.repeat_res          = rep_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.key_id              = res_r.key_id;
  assign out_ch.pressed             = res_r.pressed;
  assign out_ch.released            = res_r.released;
  assign out_ch.held                = res_r.held;
  assign out_ch.debouncing          = res_r.debouncing;
  assign out_ch.long_hold           = res_r.long_hold;
  assign out_ch.long_rel            = res_r.long_rel;
  assign out_ch.multi_press_count   = res_r.multi_press_count;
  assign out_ch.multi_release_count = res_r.multi_release_count;
  assign out_ch.repeat_res          = res_r.repeat_res;
  assign out_ch.keys_down           = res_r.keys_down;

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r && $stable(s1_key_r) && $stable(s1_time_r))
    else $error("update stage lost its word while stalled");

  a_down_limit: assert property (@(posedge clk) disable iff (!rst_n)
    down_r <= ked_pkg::DOWN_MAX)
    else $error("down count above limit");

  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.pressed && res_r.released) && !(res_r.pressed && res_r.debouncing)
                  && !(res_r.held && res_r.pressed))
    else $error("conflicting key events in one result");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.tick |=> time_r == $past(time_r) + ked_pkg::time_t'(1))
    else $error("time counter did not advance on tick");

endmodule
